FILE: src/pcfla_pkg.sv
`timescale 1ns / 1ps
package pcfla_pkg;

  // Pool geometry
  localparam int CHANNELS          = 4;
  localparam int NODES_PER_CHANNEL = 16;
  localparam int TOTAL_NODES       = CHANNELS * NODES_PER_CHANNEL;

  // Fixed field widths of the request and result words
  localparam int FUNC_W    = 1;
  localparam int CHAN_W    = 2;
  localparam int IDX_W     = 4;
  localparam int GRANT_W   = 4;
  localparam int STATUS_W  = 2;

  // Derived storage widths
  localparam int NODE_W     = $clog2(NODES_PER_CHANNEL);
  localparam int LINK_W     = $clog2(NODES_PER_CHANNEL + 1);
  localparam int ADDR_W     = (TOTAL_NODES > 1) ? $clog2(TOTAL_NODES) : 1;
  localparam int CHAN_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Null link is the value one past the last node
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NODES_PER_CHANNEL);

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY        = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NULL_HANDLE  = 2'd3;

  // One entry of the link memory
  typedef struct packed {
    logic [LINK_W-1:0] link;
    logic              free;
  } link_entry_t;

  // Write port request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    link_entry_t       data;
  } ram_wr_t;

  // Read port request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

endpackage

FILE: src/pcfla_link_ram.sv
`timescale 1ns / 1ps
module pcfla_link_ram
  import pcfla_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ram_wr_t     wr,
  input  ram_rd_t     rd,
  output link_entry_t rdata,
  output logic        rvalid
);

  link_entry_t            mem [TOTAL_NODES];
  logic [TOTAL_NODES-1:0] valid;

  // Track written entries; an unwritten entry reads back with rvalid low
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata  <= mem[rd.addr];
      rvalid <= valid[rd.addr];
    end
  end

endmodule

FILE: src/pcfla_ctrl.sv
`timescale 1ns / 1ps
module pcfla_ctrl
  import pcfla_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   func,
  input  logic [CHAN_W-1:0]   channel,
  input  logic [IDX_W-1:0]    node_index,
  input  logic                handle_present,
  output logic                done,
  output logic [GRANT_W-1:0]  granted_node,
  output logic [STATUS_W-1:0] status,
  output ram_wr_t             wr,
  output ram_rd_t             rd,
  input  link_entry_t         rdata,
  input  logic                rvalid
);

  logic [LINK_W-1:0]     heads [CHANNELS];
  logic                  pending;
  logic [FUNC_W-1:0]     func_q;
  logic                  chan_ok_q;
  logic [CHAN_IDX_W-1:0] chan_idx_q;
  logic [NODE_W-1:0]     node_q;
  logic                  null_q;
  logic [ADDR_W-1:0]     addr_q;

  logic                  accept;
  logic                  chan_ok;
  logic [CHAN_IDX_W-1:0] chan_idx;
  logic [LINK_W-1:0]     head_cur;
  logic [NODE_W-1:0]     node_sel;
  logic [ADDR_W-1:0]     addr_sel;
  logic                  node_null;
  link_entry_t           entry;
  logic [LINK_W-1:0]     head_q_cur;
  logic                  head_write;
  logic [LINK_W-1:0]     head_new;

  assign accept   = start && !busy;
  assign busy     = pending;
  assign chan_ok  = (32'(channel) < CHANNELS);
  assign chan_idx = CHAN_IDX_W'(channel);
  assign head_cur = chan_ok ? heads[chan_idx] : LINK_NULL;

  // Pick the node the request touches: list head on allocate, named node on release
  assign node_sel  = (func == FUNC_ALLOC) ? NODE_W'(head_cur) : NODE_W'(node_index);
  assign addr_sel  = ADDR_W'(32'(chan_idx) * NODES_PER_CHANNEL + 32'(node_sel));
  assign node_null = !handle_present || (32'(node_index) >= NODES_PER_CHANNEL);

  // Issue the read in the accept cycle
  assign rd.en   = accept;
  assign rd.addr = addr_sel;

  // Hold the request while the read is in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q     <= func;
      chan_ok_q  <= chan_ok;
      chan_idx_q <= chan_idx;
      node_q     <= node_sel;
      null_q     <= node_null;
      addr_q     <= addr_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else begin
      pending <= accept;
    end
  end

  // Unwritten entry: link to the following node (the last node lands on null), free
  always_comb begin
    if (rvalid) begin
      entry = rdata;
    end else begin
      entry.link = LINK_W'(node_q) + LINK_W'(1);
      entry.free = 1'b1;
    end
  end

  assign head_q_cur = heads[chan_idx_q];

  // Decide, write back and answer in the cycle after accept
  always_comb begin
    wr.en        = 1'b0;
    wr.addr      = addr_q;
    wr.data      = entry;
    head_write   = 1'b0;
    head_new     = head_q_cur;
    granted_node = '0;
    status       = ST_OK;
    if (func_q == FUNC_ALLOC) begin
      if (!chan_ok_q || head_q_cur == LINK_NULL) begin
        status = ST_EMPTY;
      end else begin
        wr.en          = pending;
        wr.data.link   = LINK_NULL;
        wr.data.free   = 1'b0;
        head_write     = pending;
        head_new       = entry.link;
        granted_node   = GRANT_W'(node_q);
      end
    end else begin
      if (!chan_ok_q || null_q) begin
        status = ST_NULL_HANDLE;
      end else if (entry.free) begin
        status = ST_ALREADY_FREE;
      end else begin
        wr.en        = pending;
        wr.data.link = head_q_cur;
        wr.data.free = 1'b1;
        head_write   = pending;
        head_new     = LINK_W'(node_q);
      end
    end
  end

  assign done = pending;

  // Advance the list heads; every list starts at node 0
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        heads[c] <= '0;
      end
    end else if (head_write) begin
      heads[chan_idx_q] <= head_new;
    end
  end

endmodule

FILE: src/per_channel_free_list_allocator_unit.sv
`timescale 1ns / 1ps
// Latency: a word accepted at one edge gives its result, with done high, in the next cycle.
// Only one word is in flight at a time, set by the link memory's read-modify-write;
// busy stays high during the result cycle and the receiver cannot stall.
// Reset (rst, synchronous): every list head returns to node 0 and every node reads
// as free and linked to its successor; a word is taken in the first cycle after reset.
module per_channel_free_list_allocator_unit
  import pcfla_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   func,
  input  logic [CHAN_W-1:0]   channel,
  input  logic [IDX_W-1:0]    node_index,
  input  logic                handle_present,
  output logic                done,
  output logic [GRANT_W-1:0]  granted_node,
  output logic [STATUS_W-1:0] status
);

  ram_wr_t     wr;
  ram_rd_t     rd;
  link_entry_t rdata;
  logic        rvalid;

  pcfla_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .channel        (channel),
    .node_index     (node_index),
    .handle_present (handle_present),
    .done           (done),
    .granted_node   (granted_node),
    .status         (status),
    .wr             (wr),
    .rd             (rd),
    .rdata          (rdata),
    .rvalid         (rvalid)
  );

  pcfla_link_ram u_ram (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .rd     (rd),
    .rdata  (rdata),
    .rvalid (rvalid)
  );

endmodule

FILE: src/pcfla_checker.sv
`timescale 1ns / 1ps
module pcfla_checker
  import pcfla_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic [FUNC_W-1:0]   func,
  input logic [CHAN_W-1:0]   channel,
  input logic [IDX_W-1:0]    node_index,
  input logic                handle_present,
  input logic                done,
  input logic [GRANT_W-1:0]  granted_node,
  input logic [STATUS_W-1:0] status
);

  // Every accepted word answers in the next cycle
  a_answer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("accepted word gave no result");

  // No result without a word accepted the cycle before
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without accepted word");

  // Busy covers the result cycle
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("new word could be taken during result");

  // Only a successful allocate carries a node
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK || $past(func) == FUNC_RELEASE)) |-> granted_node == '0)
    else $error("granted node nonzero on failed or release word");

  // A release never reports an empty pool
  a_release_status: assert property (@(posedge clk) disable iff (rst)
    (done && $past(func) == FUNC_RELEASE) |-> status != ST_EMPTY)
    else $error("release reported empty pool");

endmodule

bind per_channel_free_list_allocator_unit pcfla_checker u_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import pcfla_pkg::*;

  localparam int RANDOM_WORDS = 1750;
  localparam int IDLE_LIMIT   = 500;
  localparam int DRAIN_EVERY  = 500;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAN_W-1:0] channel;
    logic [IDX_W-1:0]  node_index;
    logic              handle_present;
  } request_t;

  typedef struct packed {
    logic [GRANT_W-1:0]  granted_node;
    logic [STATUS_W-1:0] status;
  } answer_t;

  // Mirror of the per-channel free lists plus the answers still owed by the block
  class pool_tracker;
    logic [LINK_W-1:0] link_of [TOTAL_NODES];
    logic [LINK_W-1:0] head_of [CHANNELS];
    bit                is_free [TOTAL_NODES];
    answer_t           owed_answers[$];
    int                mismatches;

    function new();
      mismatches = 0;
      for (int c = 0; c < CHANNELS; c++) begin
        head_of[c] = '0;
        for (int n = 0; n < NODES_PER_CHANNEL; n++) begin
          link_of[c*NODES_PER_CHANNEL+n] =
            (n + 1 < NODES_PER_CHANNEL) ? LINK_W'(n + 1) : LINK_NULL;
          is_free[c*NODES_PER_CHANNEL+n] = 1'b1;
        end
      end
    endfunction

    // Apply one accepted word to the lists and queue the answer it owes
    function void note_request(request_t r);
      answer_t a;
      int      base;
      int      slot;
      int      ch;
      a.granted_node = '0;
      a.status       = ST_OK;
      ch             = int'(r.channel);
      if (ch >= CHANNELS) begin
        a.status = (r.func == FUNC_ALLOC) ? ST_EMPTY : ST_NULL_HANDLE;
      end else begin
        base = ch * NODES_PER_CHANNEL;
        if (r.func == FUNC_ALLOC) begin
          // Pop the head, or report an empty pool
          if (int'(head_of[ch]) >= NODES_PER_CHANNEL) begin
            a.status = ST_EMPTY;
          end else begin
            slot           = base + int'(head_of[ch]);
            a.granted_node = GRANT_W'(head_of[ch]);
            head_of[ch]    = link_of[slot];
            link_of[slot]  = LINK_NULL;
            is_free[slot]  = 1'b0;
          end
        end else if (!r.handle_present || int'(r.node_index) >= NODES_PER_CHANNEL) begin
          a.status = ST_NULL_HANDLE;
        end else begin
          // Push the node back unless it is already on the list
          slot = base + int'(r.node_index);
          if (is_free[slot]) begin
            a.status = ST_ALREADY_FREE;
          end else begin
            link_of[slot] = head_of[ch];
            head_of[ch]   = LINK_W'(r.node_index);
            is_free[slot] = 1'b1;
          end
        end
      end
      owed_answers.push_back(a);
    endfunction

    // Compare one result word with the oldest owed answer
    function void check_answer(answer_t got);
      answer_t want;
      if (owed_answers.size() == 0) begin
        $error("result word with no request outstanding: granted_node %0d status %0d",
               got.granted_node, got.status);
        mismatches++;
      end else begin
        want = owed_answers.pop_front();
        if (got.granted_node !== want.granted_node) begin
          $error("granted_node: expected %0d, actual %0d", want.granted_node, got.granted_node);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          mismatches++;
        end
      end
    endfunction

    // Pick a node of the channel that is currently handed out, or -1
    function int pick_held(int ch);
      int held[$];
      for (int n = 0; n < NODES_PER_CHANNEL; n++) begin
        if (!is_free[ch*NODES_PER_CHANNEL+n]) begin
          held.push_back(n);
        end
      end
      if (held.size() == 0) begin
        return -1;
      end
      return held[$urandom_range(held.size() - 1)];
    endfunction
  endclass

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                start          = 1'b0;
  logic [FUNC_W-1:0]   func           = FUNC_ALLOC;
  logic [CHAN_W-1:0]   channel        = '0;
  logic [IDX_W-1:0]    node_index     = '0;
  logic                handle_present = 1'b0;
  logic                busy;
  logic                done;
  logic [GRANT_W-1:0]  granted_node;
  logic [STATUS_W-1:0] status;

  pool_tracker tracker;
  int          idle_cycles = 0;

  per_channel_free_list_allocator_unit dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .channel       (channel),
    .node_index    (node_index),
    .handle_present(handle_present),
    .done          (done),
    .granted_node  (granted_node),
    .status        (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        tracker.check_answer(answer_t'({granted_node, status}));
      end
      if (start && !busy) begin
        tracker.note_request(request_t'({func, channel, node_index, handle_present}));
      end
    end
  end

  // Abort when no word is taken for too long
  always @(posedge clk) begin
    if (rst || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic request_t make_word(logic [FUNC_W-1:0] f, int ch, int n, bit p);
    request_t r;
    r.func           = f;
    r.channel        = CHAN_W'(ch);
    r.node_index     = IDX_W'(n);
    r.handle_present = p;
    return r;
  endfunction

  // Draining favors allocates, filling favors releases of held nodes
  function automatic request_t random_word(bit filling);
    request_t r;
    int       ch;
    int       roll;
    int       held;
    ch   = $urandom_range(CHANNELS - 1);
    roll = $urandom_range(99);
    r    = make_word(FUNC_RELEASE, ch, $urandom_range(NODES_PER_CHANNEL - 1), 1'b1);
    if (roll < (filling ? 20 : 70)) begin
      r.func = FUNC_ALLOC;
    end else if (roll < 85) begin
      held = tracker.pick_held(ch);
      if (held < 0) begin
        r.func = FUNC_ALLOC;
      end else begin
        r.node_index = IDX_W'(held);
      end
    end else if (roll >= 93) begin
      r.handle_present = 1'b0;
    end
    return r;
  endfunction

  // Present one word at the falling edge and hold it until accepted
  task automatic send_word(request_t r);
    start          <= 1'b1;
    func           <= r.func;
    channel        <= r.channel;
    node_index     <= r.node_index;
    handle_present <= r.handle_present;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Drop start and scramble the fields for a number of cycles
  task automatic idle_for(int cycles);
    if (cycles > 0) begin
      start          <= 1'b0;
      func           <= FUNC_W'($urandom);
      channel        <= CHAN_W'($urandom);
      node_index     <= IDX_W'($urandom);
      handle_present <= 1'($urandom);
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Hold off until every owed answer has come back
  task automatic wait_for_answers();
    start <= 1'b0;
    do begin
      @(negedge clk);
    end while (tracker.owed_answers.size() != 0);
  endtask

  initial begin
    bit filling;
    int phase_left;
    int burst_left;
    int sent;
    tracker = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: grant, release, double release, tail release, null handles
    send_word(make_word(FUNC_ALLOC, 0, 15, 1'b1));
    send_word(make_word(FUNC_RELEASE, 0, 0, 1'b1));
    send_word(make_word(FUNC_RELEASE, 0, 0, 1'b1));
    send_word(make_word(FUNC_RELEASE, 1, NODES_PER_CHANNEL - 1, 1'b1));
    send_word(make_word(FUNC_RELEASE, 2, NODES_PER_CHANNEL - 1, 1'b0));
    send_word(make_word(FUNC_RELEASE, 3, 0, 1'b0));
    // Directed: exhaust one pool, then refill and regrant its tail node
    for (int i = 0; i <= NODES_PER_CHANNEL; i++) begin
      send_word(make_word(FUNC_ALLOC, CHANNELS - 1, (i % 2) ? 15 : 0, 1'(i % 2)));
    end
    send_word(make_word(FUNC_RELEASE, CHANNELS - 1, NODES_PER_CHANNEL - 1, 1'b1));
    send_word(make_word(FUNC_ALLOC, CHANNELS - 1, 0, 1'b0));
    wait_for_answers();

    // Random: bursts with gaps, alternating drain and fill phases
    sent       = 0;
    filling    = 1'b0;
    phase_left = $urandom_range(60, 200);
    while (sent < RANDOM_WORDS) begin
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      while (burst_left > 0 && sent < RANDOM_WORDS) begin
        if (phase_left == 0) begin
          filling    = !filling;
          phase_left = $urandom_range(60, 200);
        end
        send_word(random_word(filling));
        sent++;
        phase_left--;
        burst_left--;
        if (sent % DRAIN_EVERY == 0) begin
          wait_for_answers();
        end
      end
      idle_for($urandom_range(1, 6));
    end

    // Settle: wait out the last answers, then a few spare cycles
    start <= 1'b0;
    while (tracker.owed_answers.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
    if (tracker.owed_answers.size() != 0) begin
      $error("%0d answers never arrived", tracker.owed_answers.size());
      tracker.mismatches++;
    end
    if (tracker.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: per_channel_free_list_allocator_unit.f
src/pcfla_pkg.sv
src/pcfla_link_ram.sv
src/pcfla_ctrl.sv
src/per_channel_free_list_allocator_unit.sv
src/pcfla_checker.sv
verif/tb_top.sv
